>>> rtl/vapf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapf_pkg
// shared types, constants and helpers of the vehicle activity power monitor
// ----------------------------------------------------------------------------
package vapf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] AWAKE_MILLIVOLTS   = 16'd11500;
  localparam logic [7:0]  LOAD_THRESHOLD     = 8'd10;
  localparam logic [7:0]  THROTTLE_THRESHOLD = 8'd5;
  localparam logic [31:0] BOOT_SETTLE_MS     = 32'd1500;

  localparam logic [31:0] CAN_TIMEOUT_RST   = 32'd2000;
  localparam logic [31:0] OBD_TIMEOUT_RST   = 32'd3000;
  localparam logic [31:0] USER_TIMEOUT_RST  = 32'd5000;
  localparam logic [31:0] PARK_TIMEOUT_RST  = 32'd60000;
  localparam logic [31:0] SLEEP_DELAY_RST   = 32'd30000;
  localparam logic [13:0] RPM_THRESHOLD_RST = 14'd400;
  localparam logic [7:0]  SPEED_THRESH_RST  = 8'd3;
  localparam logic [1:0]  MODE_BITS_RST     = 2'd3;

  localparam int unsigned MODE_PM_EN = 0;
  localparam int unsigned MODE_SS_EN = 1;

  typedef enum logic [2:0] {
    CFG_CAN_TIMEOUT  = 3'd0,
    CFG_OBD_TIMEOUT  = 3'd1,
    CFG_USER_TIMEOUT = 3'd2,
    CFG_PARK_TIMEOUT = 3'd3,
    CFG_SLEEP_DELAY  = 3'd4,
    CFG_RPM_THRESH   = 3'd5,
    CFG_SPEED_THRESH = 3'd6,
    CFG_MODE_BITS    = 3'd7
  } cfg_idx_t;

  typedef enum logic [5:0] {
    VS_BOOTING   = 6'b000001,
    VS_RUNNING   = 6'b000010,
    VS_STARTSTOP = 6'b000100,
    VS_IDLE      = 6'b001000,
    VS_PARKED    = 6'b010000,
    VS_DSLEEP    = 6'b100000
  } vstate_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_SLEEP  = 2'd1,
    CMD_WAKEUP = 2'd2
  } pcmd_t;

  localparam logic [2:0] CODE_BOOTING   = 3'd0;
  localparam logic [2:0] CODE_RUNNING   = 3'd1;
  localparam logic [2:0] CODE_STARTSTOP = 3'd2;
  localparam logic [2:0] CODE_IDLE      = 3'd3;
  localparam logic [2:0] CODE_PARKED    = 3'd4;
  localparam logic [2:0] CODE_DSLEEP    = 3'd5;

  typedef struct packed {
    logic [31:0] can_timeout_ms;
    logic [31:0] obd_timeout_ms;
    logic [31:0] user_timeout_ms;
    logic [31:0] park_timeout_ms;
    logic [31:0] sleep_delay_ms;
    logic [13:0] rpm_threshold;
    logic [7:0]  speed_threshold;
    logic [1:0]  mode_bits;
  } cfg_t;

  typedef struct packed {
    logic can_active;
    logic obd_active;
    logic engine_on;
    logic is_moving;
    logic board_awake;
    logic user_active;
  } flags_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [31:0] now_ms;
    vstate_t     sel;
    logic [4:0]  score;
    flags_t      flags;
  } cls_t;

  function automatic logic [2:0] state_code(vstate_t s);
    logic [2:0] c;
    case (s)
      VS_BOOTING:   c = CODE_BOOTING;
      VS_RUNNING:   c = CODE_RUNNING;
      VS_STARTSTOP: c = CODE_STARTSTOP;
      VS_IDLE:      c = CODE_IDLE;
      VS_PARKED:    c = CODE_PARKED;
      VS_DSLEEP:    c = CODE_DSLEEP;
      default:      c = CODE_BOOTING;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/vapf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapf_in_if
// update tick channel: valid, ready and the tick word
// ----------------------------------------------------------------------------
interface vapf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [31:0] last_can_ms;
  logic [31:0] last_obd_ms;
  logic [31:0] last_user_ms;
  logic [31:0] boot_done_ms;
  logic [13:0] engine_rpm;
  logic [7:0]  speed_kph;
  logic [15:0] battery_mv;
  logic [7:0]  load_percent;
  logic [7:0]  throttle_percent;
  logic        sim_active;

  modport source (
    output valid, now_ms, last_can_ms, last_obd_ms, last_user_ms, boot_done_ms,
           engine_rpm, speed_kph, battery_mv, load_percent, throttle_percent,
           sim_active,
    input  ready
  );

  modport sink (
    input  valid, now_ms, last_can_ms, last_obd_ms, last_user_ms, boot_done_ms,
           engine_rpm, speed_kph, battery_mv, load_percent, throttle_percent,
           sim_active,
    output ready
  );
endinterface

>>> rtl/vapf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapf_out_if
// result channel: valid, ready and the status word
// ----------------------------------------------------------------------------
interface vapf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  vehicle_state;
  logic [1:0]  power_command;
  logic [4:0]  activity_score;
  logic        can_active;
  logic        obd_active;
  logic        engine_on;
  logic        is_moving;
  logic        board_awake;
  logic        user_active;
  logic [31:0] idle_since_ms;
  logic [31:0] parked_since_ms;
  logic [31:0] sleep_due_ms;

  modport source (
    output valid, vehicle_state, power_command, activity_score, can_active,
           obd_active, engine_on, is_moving, board_awake, user_active,
           idle_since_ms, parked_since_ms, sleep_due_ms,
    input  ready
  );

  modport sink (
    input  valid, vehicle_state, power_command, activity_score, can_active,
           obd_active, engine_on, is_moving, board_awake, user_active,
           idle_since_ms, parked_since_ms, sleep_due_ms,
    output ready
  );
endinterface

>>> rtl/vehicle_activity_power_fsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_activity_power_fsm_core
// vehicle activity monitor and power state selector, one word per tick
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one tick word (time, last activity times, boot time and
//   vehicle readings); out_ch returns one status word per tick: vehicle
//   state, power command, activity flags, score and idle/park timestamps.
//   cfg_we/cfg_idx/cfg_wdata write the eight settings; write only while idle.
// path: out_ch.valid rises once an accepted word has passed the queue and the
//   state update has loaded it into the output register.
// throughput: one word per cycle while out_ch.ready is high; the state register
//   update in the back end is the loop that sets it.
// reset: state returns to booting, timestamps to zero, settings to their
//   defaults, queue and output register empty.
// stall: while out_ch.ready is low the output holds; the queue absorbs
//   QUEUE_DEPTH more words, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module vehicle_activity_power_fsm_core #(
  parameter int unsigned QUEUE_DEPTH = vapf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  vapf_in_if.sink     in_ch,
  vapf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  vapf_pkg::cfg_t cfg_r;
  vapf_pkg::cls_t push_data, head_data;
  logic           q_ready, q_push, head_valid, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.can_timeout_ms  <= vapf_pkg::CAN_TIMEOUT_RST;
      cfg_r.obd_timeout_ms  <= vapf_pkg::OBD_TIMEOUT_RST;
      cfg_r.user_timeout_ms <= vapf_pkg::USER_TIMEOUT_RST;
      cfg_r.park_timeout_ms <= vapf_pkg::PARK_TIMEOUT_RST;
      cfg_r.sleep_delay_ms  <= vapf_pkg::SLEEP_DELAY_RST;
      cfg_r.rpm_threshold   <= vapf_pkg::RPM_THRESHOLD_RST;
      cfg_r.speed_threshold <= vapf_pkg::SPEED_THRESH_RST;
      cfg_r.mode_bits       <= vapf_pkg::MODE_BITS_RST;
    end else if (cfg_we) begin
      case (vapf_pkg::cfg_idx_t'(cfg_idx))
        vapf_pkg::CFG_CAN_TIMEOUT:  cfg_r.can_timeout_ms  <= cfg_wdata;
        vapf_pkg::CFG_OBD_TIMEOUT:  cfg_r.obd_timeout_ms  <= cfg_wdata;
        vapf_pkg::CFG_USER_TIMEOUT: cfg_r.user_timeout_ms <= cfg_wdata;
        vapf_pkg::CFG_PARK_TIMEOUT: cfg_r.park_timeout_ms <= cfg_wdata;
        vapf_pkg::CFG_SLEEP_DELAY:  cfg_r.sleep_delay_ms  <= cfg_wdata;
        vapf_pkg::CFG_RPM_THRESH:   cfg_r.rpm_threshold   <= cfg_wdata[13:0];
        vapf_pkg::CFG_SPEED_THRESH: cfg_r.speed_threshold <= cfg_wdata[7:0];
        vapf_pkg::CFG_MODE_BITS:    cfg_r.mode_bits       <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  vapf_front u_front (
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (push_data)
  );

  vapf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_data),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  vapf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

>>> rtl/vapf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapf_front
// accepts tick words, derives activity flags, score and candidate state
// ----------------------------------------------------------------------------
module vapf_front (
  vapf_in_if.sink       in_ch,
  input  vapf_pkg::cfg_t cfg,
  input  logic          q_ready,
  output logic          q_push,
  output vapf_pkg::cls_t q_data
);

  function automatic logic seen_within(logic [31:0] now, logic [31:0] last,
                                       logic [31:0] limit);
    logic [31:0] age;
    age = now - last;
    return (last != 32'd0) && (now >= last) && (age <= limit);
  endfunction

  logic           can_on, obd_on, eng, mov, awake, user, load_hi, thr_hi;
  logic [31:0]    boot_age, can_age, obd_age;
  logic           booting, park_elapsed;
  vapf_pkg::vstate_t sel;

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid & q_ready;

  assign can_on  = seen_within(in_ch.now_ms, in_ch.last_can_ms, cfg.can_timeout_ms);
  assign obd_on  = seen_within(in_ch.now_ms, in_ch.last_obd_ms, cfg.obd_timeout_ms);
  assign user    = seen_within(in_ch.now_ms, in_ch.last_user_ms, cfg.user_timeout_ms);
  assign eng     = in_ch.engine_rpm >= cfg.rpm_threshold;
  assign mov     = in_ch.speed_kph >= cfg.speed_threshold;
  assign awake   = in_ch.battery_mv >= vapf_pkg::AWAKE_MILLIVOLTS;
  assign load_hi = in_ch.load_percent >= vapf_pkg::LOAD_THRESHOLD;
  assign thr_hi  = in_ch.throttle_percent >= vapf_pkg::THROTTLE_THRESHOLD;

  assign boot_age = in_ch.now_ms - in_ch.boot_done_ms;
  assign can_age  = in_ch.now_ms - in_ch.last_can_ms;
  assign obd_age  = in_ch.now_ms - in_ch.last_obd_ms;
  assign booting  = (in_ch.boot_done_ms == 32'd0) || (boot_age < vapf_pkg::BOOT_SETTLE_MS);
  assign park_elapsed = !can_on && !obd_on && (in_ch.last_can_ms != 32'd0) &&
                        (in_ch.last_obd_ms != 32'd0) &&
                        (can_age >= cfg.park_timeout_ms) && (obd_age >= cfg.park_timeout_ms);

  always_comb begin
    q_data.now_ms = in_ch.now_ms;
    q_data.score  = (can_on ? 5'd5 : 5'd0) + (obd_on ? 5'd5 : 5'd0) +
                    (eng ? 5'd3 : 5'd0) + (mov ? 5'd3 : 5'd0) +
                    (load_hi ? 5'd2 : 5'd0) + (thr_hi ? 5'd2 : 5'd0) +
                    (awake ? 5'd2 : 5'd0) + (user ? 5'd1 : 5'd0) +
                    (in_ch.sim_active ? 5'd5 : 5'd0);
    q_data.flags.can_active  = can_on;
    q_data.flags.obd_active  = obd_on;
    q_data.flags.engine_on   = eng;
    q_data.flags.is_moving   = mov;
    q_data.flags.board_awake = awake;
    q_data.flags.user_active = user;

    if (!cfg.mode_bits[vapf_pkg::MODE_PM_EN]) begin
      sel = vapf_pkg::VS_RUNNING;
    end else if (booting) begin
      sel = vapf_pkg::VS_BOOTING;
    end else if (eng || mov) begin
      sel = vapf_pkg::VS_RUNNING;
    end else if (park_elapsed && !in_ch.sim_active) begin
      sel = vapf_pkg::VS_PARKED;
    end else if (cfg.mode_bits[vapf_pkg::MODE_SS_EN] && can_on && obd_on && awake) begin
      sel = vapf_pkg::VS_STARTSTOP;
    end else if (can_on || obd_on || awake || user) begin
      sel = vapf_pkg::VS_IDLE;
    end else if (q_data.score == 5'd0) begin
      sel = vapf_pkg::VS_PARKED;
    end else begin
      sel = vapf_pkg::VS_IDLE;
    end
    q_data.sel = sel;
  end

endmodule

>>> rtl/vapf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapf_queue
// short first-in first-out queue of classified words between front and back
// ----------------------------------------------------------------------------
module vapf_queue #(
  parameter int unsigned DEPTH = vapf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vapf_pkg::cls_t push_data,
  output logic           ready,
  input  logic           pop,
  output logic           head_valid,
  output vapf_pkg::cls_t head_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  vapf_pkg::cls_t q_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign ready      = count_r != CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_data  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count above depth");
`endif

endmodule

>>> rtl/vapf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vapf_back
// applies the state transition, timestamps and power command per word
// ----------------------------------------------------------------------------
module vapf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  vapf_pkg::cfg_t cfg,
  input  logic           head_valid,
  input  vapf_pkg::cls_t head_data,
  output logic           pop,
  vapf_out_if.source     out_ch
);

  vapf_pkg::vstate_t prev_r, fin;
  logic [31:0]       idle_r, idle_nxt, park_r, park_nxt, dl_r, dl_nxt;
  logic              out_valid_r;
  vapf_pkg::pcmd_t   cmd_r, cmd;
  logic [4:0]        score_r;
  vapf_pkg::flags_t  flags_r;
  logic              prev_park, prev_sleep, fin_awake;

  assign pop = head_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    idle_nxt = idle_r;
    park_nxt = park_r;
    dl_nxt   = dl_r;
    if (head_data.sel == vapf_pkg::VS_IDLE && prev_r != vapf_pkg::VS_IDLE) begin
      idle_nxt = head_data.now_ms;
    end
    if (head_data.sel == vapf_pkg::VS_PARKED) begin
      if (prev_r != vapf_pkg::VS_PARKED) begin
        park_nxt = head_data.now_ms;
        dl_nxt   = head_data.now_ms + cfg.sleep_delay_ms;
      end
    end else begin
      park_nxt = 32'd0;
      dl_nxt   = 32'd0;
    end

    fin = head_data.sel;
    if (head_data.sel == vapf_pkg::VS_PARKED && dl_nxt != 32'd0 &&
        head_data.now_ms >= dl_nxt) begin
      fin = vapf_pkg::VS_DSLEEP;
    end

    prev_park  = prev_r == vapf_pkg::VS_PARKED;
    prev_sleep = prev_r == vapf_pkg::VS_DSLEEP;
    fin_awake  = fin == vapf_pkg::VS_RUNNING || fin == vapf_pkg::VS_STARTSTOP ||
                 fin == vapf_pkg::VS_IDLE;
    if (fin == vapf_pkg::VS_DSLEEP && !prev_sleep) begin
      cmd = vapf_pkg::CMD_SLEEP;
    end else if (prev_sleep && fin != vapf_pkg::VS_DSLEEP) begin
      cmd = vapf_pkg::CMD_WAKEUP;
    end else if (prev_park && fin_awake) begin
      cmd = vapf_pkg::CMD_WAKEUP;
    end else begin
      cmd = vapf_pkg::CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= vapf_pkg::VS_BOOTING;
      idle_r      <= 32'd0;
      park_r      <= 32'd0;
      dl_r        <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        prev_r      <= fin;
        idle_r      <= idle_nxt;
        park_r      <= park_nxt;
        dl_r        <= dl_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r   <= cmd;
      score_r <= head_data.score;
      flags_r <= head_data.flags;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.vehicle_state   = vapf_pkg::state_code(prev_r);
  assign out_ch.power_command   = cmd_r;
  assign out_ch.activity_score  = score_r;
  assign out_ch.can_active      = flags_r.can_active;
  assign out_ch.obd_active      = flags_r.obd_active;
  assign out_ch.engine_on       = flags_r.engine_on;
  assign out_ch.is_moving       = flags_r.is_moving;
  assign out_ch.board_awake     = flags_r.board_awake;
  assign out_ch.user_active     = flags_r.user_active;
  assign out_ch.idle_since_ms   = idle_r;
  assign out_ch.parked_since_ms = park_r;
  assign out_ch.sleep_due_ms    = dl_r;

`ifndef ASSERT_OFF
  a_park_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (prev_r != vapf_pkg::VS_PARKED && prev_r != vapf_pkg::VS_DSLEEP) |->
      (park_r == 32'd0 && dl_r == 32'd0))
    else $error("park timestamps set outside parked states");
`endif

`ifndef ASSERT_OFF
  a_sleep_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && cmd_r == vapf_pkg::CMD_SLEEP) |-> prev_r == vapf_pkg::VS_DSLEEP)
    else $error("sleep command without display sleep state");
`endif

`ifndef ASSERT_OFF
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("popped word did not reach output register");
`endif

endmodule

>>> tb/sv/vehicle_activity_power_fsm_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_activity_power_fsm_core_test
// self-checking bench for the vehicle activity and power state monitor
// ----------------------------------------------------------------------------
// Drives update ticks over the input channel and compares every status word
// with a cycle-free software copy of the state selector. Directed ticks hit
// boot settling, thresholds, park entry, display sleep and time wrap; the
// random part replays drive and parked sessions with random content plus
// noise ticks, under several settings and with sender and receiver idling,
// including one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module vehicle_activity_power_fsm_core_test;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] last_can_ms;
    logic [31:0] last_obd_ms;
    logic [31:0] last_user_ms;
    logic [31:0] boot_done_ms;
    logic [13:0] engine_rpm;
    logic [7:0]  speed_kph;
    logic [15:0] battery_mv;
    logic [7:0]  load_percent;
    logic [7:0]  throttle_percent;
    logic        sim_active;
  } tick_t;

  typedef struct packed {
    logic [2:0]        vehicle_state;
    logic [1:0]        power_command;
    logic [4:0]        activity_score;
    vapf_pkg::flags_t  flags;
    logic [31:0]       idle_since_ms;
    logic [31:0]       parked_since_ms;
    logic [31:0]       sleep_due_ms;
  } status_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  vapf_in_if  in_ch ();
  vapf_out_if out_ch ();

  vehicle_activity_power_fsm_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the settings and the state register
  vapf_pkg::cfg_t settings = '{vapf_pkg::CAN_TIMEOUT_RST, vapf_pkg::OBD_TIMEOUT_RST,
                               vapf_pkg::USER_TIMEOUT_RST, vapf_pkg::PARK_TIMEOUT_RST,
                               vapf_pkg::SLEEP_DELAY_RST, vapf_pkg::RPM_THRESHOLD_RST,
                               vapf_pkg::SPEED_THRESH_RST, vapf_pkg::MODE_BITS_RST};
  logic [2:0]  vstate_code   = vapf_pkg::CODE_BOOTING;
  logic [31:0] idle_mark_ms  = '0;
  logic [31:0] park_mark_ms  = '0;
  logic [31:0] sleep_mark_ms = '0;

  status_t pending_status[$];
  int      error_count   = 0;
  int      stall_cycles  = 0;
  int      in_idle_pct   = 0;
  int      out_stall_pct = 0;
  int      hold_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic seen_recent(logic [31:0] now, logic [31:0] last,
                                       logic [31:0] limit);
    return (last != 32'd0) && (now >= last) && ((now - last) <= limit);
  endfunction

  function automatic status_t predict_status(tick_t t);
    status_t         s;
    logic            can_on, obd_on, eng, mov, awake, usr, aged_out;
    logic [4:0]      score;
    logic [2:0]      sel, fin, prev;
    vapf_pkg::pcmd_t cmd;
    can_on = seen_recent(t.now_ms, t.last_can_ms, settings.can_timeout_ms);
    obd_on = seen_recent(t.now_ms, t.last_obd_ms, settings.obd_timeout_ms);
    usr    = seen_recent(t.now_ms, t.last_user_ms, settings.user_timeout_ms);
    eng    = t.engine_rpm >= settings.rpm_threshold;
    mov    = t.speed_kph >= settings.speed_threshold;
    awake  = t.battery_mv >= vapf_pkg::AWAKE_MILLIVOLTS;
    score  = 5'd0;
    if (can_on) score = score + 5'd5;
    if (obd_on) score = score + 5'd5;
    if (eng) score = score + 5'd3;
    if (mov) score = score + 5'd3;
    if (t.load_percent >= vapf_pkg::LOAD_THRESHOLD) score = score + 5'd2;
    if (t.throttle_percent >= vapf_pkg::THROTTLE_THRESHOLD) score = score + 5'd2;
    if (awake) score = score + 5'd2;
    if (usr) score = score + 5'd1;
    if (t.sim_active) score = score + 5'd5;

    if (!settings.mode_bits[vapf_pkg::MODE_PM_EN]) begin
      sel = vapf_pkg::CODE_RUNNING;
    end else if (t.boot_done_ms == 32'd0 ||
                 (t.now_ms - t.boot_done_ms) < vapf_pkg::BOOT_SETTLE_MS) begin
      sel = vapf_pkg::CODE_BOOTING;
    end else if (eng || mov) begin
      sel = vapf_pkg::CODE_RUNNING;
    end else begin
      aged_out = !can_on && !obd_on && t.last_can_ms != 32'd0 &&
                 t.last_obd_ms != 32'd0 &&
                 (t.now_ms - t.last_can_ms) >= settings.park_timeout_ms &&
                 (t.now_ms - t.last_obd_ms) >= settings.park_timeout_ms;
      if (aged_out && !t.sim_active) begin
        sel = vapf_pkg::CODE_PARKED;
      end else if (settings.mode_bits[vapf_pkg::MODE_SS_EN] && can_on && obd_on &&
                   awake) begin
        sel = vapf_pkg::CODE_STARTSTOP;
      end else if (can_on || obd_on || awake || usr) begin
        sel = vapf_pkg::CODE_IDLE;
      end else if (score == 5'd0) begin
        sel = vapf_pkg::CODE_PARKED;
      end else begin
        sel = vapf_pkg::CODE_IDLE;
      end
    end

    prev = vstate_code;
    if (sel == vapf_pkg::CODE_IDLE && prev != vapf_pkg::CODE_IDLE) idle_mark_ms = t.now_ms;
    if (sel == vapf_pkg::CODE_PARKED && prev != vapf_pkg::CODE_PARKED) begin
      park_mark_ms  = t.now_ms;
      sleep_mark_ms = t.now_ms + settings.sleep_delay_ms;
    end
    if (sel != vapf_pkg::CODE_PARKED && sel != vapf_pkg::CODE_DSLEEP) begin
      park_mark_ms  = 32'd0;
      sleep_mark_ms = 32'd0;
    end

    fin = sel;
    if (sel == vapf_pkg::CODE_PARKED && sleep_mark_ms != 32'd0 && t.now_ms >= sleep_mark_ms)
      fin = vapf_pkg::CODE_DSLEEP;

    if (fin == vapf_pkg::CODE_DSLEEP && prev != vapf_pkg::CODE_DSLEEP) begin
      cmd = vapf_pkg::CMD_SLEEP;
    end else if (prev == vapf_pkg::CODE_DSLEEP && fin != vapf_pkg::CODE_DSLEEP) begin
      cmd = vapf_pkg::CMD_WAKEUP;
    end else if ((prev == vapf_pkg::CODE_PARKED || prev == vapf_pkg::CODE_DSLEEP) &&
                 (fin == vapf_pkg::CODE_RUNNING || fin == vapf_pkg::CODE_STARTSTOP ||
                  fin == vapf_pkg::CODE_IDLE)) begin
      cmd = vapf_pkg::CMD_WAKEUP;
    end else begin
      cmd = vapf_pkg::CMD_NONE;
    end
    vstate_code = fin;

    s.vehicle_state     = fin;
    s.power_command     = cmd;
    s.activity_score    = score;
    s.flags.can_active  = can_on;
    s.flags.obd_active  = obd_on;
    s.flags.engine_on   = eng;
    s.flags.is_moving   = mov;
    s.flags.board_awake = awake;
    s.flags.user_active = usr;
    s.idle_since_ms     = idle_mark_ms;
    s.parked_since_ms   = park_mark_ms;
    s.sleep_due_ms      = sleep_mark_ms;
    return s;
  endfunction

  function automatic tick_t mk_tick(logic [31:0] now, logic [31:0] lcan,
                                    logic [31:0] lobd, logic [31:0] luser,
                                    logic [31:0] boot, logic [13:0] rpm,
                                    logic [7:0] spd, logic [15:0] batt,
                                    logic [7:0] load, logic [7:0] thr, logic sim);
    tick_t t;
    t = '{now, lcan, lobd, luser, boot, rpm, spd, batt, load, thr, sim};
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic send_tick(input tick_t t);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.now_ms           <= t.now_ms;
    in_ch.last_can_ms      <= t.last_can_ms;
    in_ch.last_obd_ms      <= t.last_obd_ms;
    in_ch.last_user_ms     <= t.last_user_ms;
    in_ch.boot_done_ms     <= t.boot_done_ms;
    in_ch.engine_rpm       <= t.engine_rpm;
    in_ch.speed_kph        <= t.speed_kph;
    in_ch.battery_mv       <= t.battery_mv;
    in_ch.load_percent     <= t.load_percent;
    in_ch.throttle_percent <= t.throttle_percent;
    in_ch.sim_active       <= t.sim_active;
    in_ch.valid            <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_status.push_back(predict_status(t));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input vapf_pkg::cfg_t c);
    vapf_pkg::cfg_idx_t idx;
    logic [31:0]        word;
    idx = idx.first();
    do begin
      word = $urandom;
      case (idx)
        vapf_pkg::CFG_CAN_TIMEOUT:  word = c.can_timeout_ms;
        vapf_pkg::CFG_OBD_TIMEOUT:  word = c.obd_timeout_ms;
        vapf_pkg::CFG_USER_TIMEOUT: word = c.user_timeout_ms;
        vapf_pkg::CFG_PARK_TIMEOUT: word = c.park_timeout_ms;
        vapf_pkg::CFG_SLEEP_DELAY:  word = c.sleep_delay_ms;
        vapf_pkg::CFG_RPM_THRESH:   word[13:0] = c.rpm_threshold;
        vapf_pkg::CFG_SPEED_THRESH: word[7:0] = c.speed_threshold;
        vapf_pkg::CFG_MODE_BITS:    word[1:0] = c.mode_bits;
        default: ;
      endcase
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= word;
      idx = idx.next();
    end while (idx != idx.first());
    @(negedge clk);
    cfg_we <= 1'b0;
    settings = c;
  endtask

  function automatic vapf_pkg::cfg_t rand_config();
    vapf_pkg::cfg_t c;
    c.can_timeout_ms  = $urandom_range(50, 5000);
    c.obd_timeout_ms  = $urandom_range(50, 5000);
    c.user_timeout_ms = $urandom_range(50, 8000);
    c.park_timeout_ms = $urandom_range(500, 80000);
    c.sleep_delay_ms  = ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(1, 40000);
    c.rpm_threshold   = 14'($urandom_range(100, 3000));
    c.speed_threshold = 8'($urandom_range(1, 20));
    c.mode_bits       = ($urandom_range(9) < 7) ? 2'd3 : 2'($urandom_range(0, 3));
    return c;
  endfunction

  // drive and parked sessions on a running clock, with noise ticks mixed in
  task automatic run_traffic(input int n_items);
    int          sent;
    int          left;
    bit          driving;
    int unsigned step_max;
    logic [31:0] now, boot, lcan, lobd, luser;
    tick_t       t;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(5) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 300000);
      else now = $urandom_range(1000, 32'h4000_0000);
      boot  = ($urandom_range(9) == 0) ? 32'd0 : now - $urandom_range(0, 3000);
      lcan  = now;
      lobd  = now;
      luser = 32'd0;
      case ($urandom_range(3))
        0: step_max = 20;
        1: step_max = 400;
        2: step_max = 4000;
        default: step_max = settings.park_timeout_ms / 8 + 1;
      endcase
      left = $urandom_range(2, 6);
      while (left > 0 && sent < n_items) begin
        driving = $urandom_range(1);
        repeat (driving ? $urandom_range(3, 15) : $urandom_range(5, 50)) begin
          now = now + $urandom_range(1, step_max);
          if (driving || $urandom_range(9) == 0) begin
            if ($urandom_range(9) < 8) lcan = now - $urandom_range(0, 40);
            if ($urandom_range(9) < 7) lobd = now - $urandom_range(0, 40);
          end
          if ($urandom_range(19) < (driving ? 6 : 1)) luser = now;
          if ($urandom_range(29) == 0) lcan = now + $urandom_range(1, 100);
          if (boot == 32'd0 && $urandom_range(3) == 0) boot = now;
          t.now_ms       = now;
          t.last_can_ms  = lcan;
          t.last_obd_ms  = lobd;
          t.last_user_ms = luser;
          t.boot_done_ms = boot;
          if (driving) begin
            t.engine_rpm = $urandom_range(1) ? 14'($urandom_range(0, 16383)) :
                                               14'($urandom_range(0, 800));
            t.speed_kph  = 8'($urandom_range(0, 255));
          end else begin
            t.engine_rpm = ($urandom_range(4) == 0) ? 14'($urandom_range(0, 500)) : 14'd0;
            t.speed_kph  = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 4)) : 8'd0;
          end
          t.battery_mv       = 16'($urandom_range(10500, 14500));
          t.load_percent     = 8'($urandom_range(0, driving ? 100 : 12));
          t.throttle_percent = 8'($urandom_range(0, driving ? 100 : 6));
          t.sim_active       = ($urandom_range(24) == 0);
          if ($urandom_range(9) == 0) begin
            t.now_ms           = $urandom;
            t.last_can_ms      = $urandom;
            t.last_obd_ms      = $urandom;
            t.last_user_ms     = $urandom;
            t.boot_done_ms     = $urandom;
            t.engine_rpm       = 14'($urandom_range(0, 16383));
            t.speed_kph        = 8'($urandom_range(0, 255));
            t.battery_mv       = 16'($urandom_range(0, 65535));
            t.load_percent     = 8'($urandom_range(0, 255));
            t.throttle_percent = 8'($urandom_range(0, 255));
            t.sim_active       = 1'($urandom_range(1));
          end
          send_tick(t);
          sent++;
        end
        left--;
      end
    end
  endtask

  task automatic test_directed_defaults();
    tick_t dir[$];
    in_idle_pct   = 0;
    out_stall_pct = 0;
    dir.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(1000, 0, 0, 0, 0, 0, 0, 12000, 9, 4, 0));
    dir.push_back(mk_tick(2000, 1990, 0, 0, 501, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(2001, 2001, 2001, 2001, 501, 400, 0, 11500, 10, 5, 0));
    dir.push_back(mk_tick(2100, 2001, 2001, 0, 501, 399, 3, 11499, 0, 0, 0));
    dir.push_back(mk_tick(2200, 200, 100, 0, 501, 0, 2, 11500, 0, 0, 0));
    dir.push_back(mk_tick(2300, 200, 100, 0, 501, 0, 0, 11499, 0, 0, 0));
    dir.push_back(mk_tick(4000, 200, 100, 4000, 501, 0, 0, 0, 0, 0, 0));
    // bus silent past park timeout, then sleep deadline, then re-entry
    dir.push_back(mk_tick(70000, 5000, 5000, 0, 501, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(80000, 5000, 5000, 0, 501, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(100000, 5000, 5000, 0, 501, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(100500, 5000, 5000, 0, 501, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(140000, 5000, 5000, 0, 501, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(141000, 5000, 5000, 0, 501, 3000, 50, 13800, 60, 30, 0));
    dir.push_back(mk_tick(200000, 5000, 5000, 0, 501, 0, 0, 0, 0, 0, 1));
    dir.push_back(mk_tick(210000, 0, 0, 0, 501, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(220000, 230000, 0, 230000, 501, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(225000, 224000, 0, 0, 501, 0, 0, 0, 0, 0, 0));
    // time wrap
    dir.push_back(mk_tick(32'hFFFF_FF00, 32'hFFFF_FE00, 32'hFFFF_FF00, 32'hFFFF_FF00,
                          32'hFFFF_F000, 0, 0, 16'hFFFF, 8'hFF, 8'hFF, 0));
    dir.push_back(mk_tick(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0100, 0,
                          32'hFFFF_F000, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 14'h3FFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1));
    dir.push_back(mk_tick(1000, 1000, 1000, 0, 1001, 0, 0, 11500, 0, 0, 0));
    // deadline wraps below now, so parked turns to sleep at once
    dir.push_back(mk_tick(32'hFFFF_FFFF, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0));
    foreach (dir[i]) send_tick(dir[i]);
  endtask

  task automatic test_traffic(input int sender_idle, input int receiver_stall,
                              input int n_items);
    wait_drained();
    apply_config(rand_config());
    in_idle_pct   = sender_idle;
    out_stall_pct = receiver_stall;
    run_traffic(n_items);
  endtask

  task automatic test_config_extremes();
    wait_drained();
    apply_config('0);
    in_idle_pct   = 20;
    out_stall_pct = 20;
    run_traffic(60);
    wait_drained();
    apply_config('1);
    run_traffic(60);
  endtask

  task automatic test_output_hold_off();
    wait_drained();
    apply_config(rand_config());
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_cycles   = 300;
    run_traffic(120);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_status
    status_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_status.size() == 0) begin
        report_mismatch("status word with no tick pending");
      end else begin
        want = pending_status.pop_front();
        check_field("vehicle_state", 32'(out_ch.vehicle_state), 32'(want.vehicle_state));
        check_field("power_command", 32'(out_ch.power_command), 32'(want.power_command));
        check_field("activity_score", 32'(out_ch.activity_score),
                    32'(want.activity_score));
        check_field("can_active", 32'(out_ch.can_active), 32'(want.flags.can_active));
        check_field("obd_active", 32'(out_ch.obd_active), 32'(want.flags.obd_active));
        check_field("engine_on", 32'(out_ch.engine_on), 32'(want.flags.engine_on));
        check_field("is_moving", 32'(out_ch.is_moving), 32'(want.flags.is_moving));
        check_field("board_awake", 32'(out_ch.board_awake), 32'(want.flags.board_awake));
        check_field("user_active", 32'(out_ch.user_active), 32'(want.flags.user_active));
        check_field("idle_since_ms", out_ch.idle_since_ms, want.idle_since_ms);
        check_field("parked_since_ms", out_ch.parked_since_ms, want.parked_since_ms);
        check_field("sleep_due_ms", out_ch.sleep_due_ms, want.sleep_due_ms);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = vapf_pkg::CFG_CAN_TIMEOUT;
    cfg_wdata              = '0;
    in_ch.valid            = 1'b0;
    in_ch.now_ms           = '0;
    in_ch.last_can_ms      = '0;
    in_ch.last_obd_ms      = '0;
    in_ch.last_user_ms     = '0;
    in_ch.boot_done_ms     = '0;
    in_ch.engine_rpm       = '0;
    in_ch.speed_kph        = '0;
    in_ch.battery_mv       = '0;
    in_ch.load_percent     = '0;
    in_ch.throttle_percent = '0;
    in_ch.sim_active       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_traffic(0, 0, 330);
    test_traffic(51, 0, 330);
    test_traffic(0, 51, 330);
    test_traffic(34, 34, 330);
    test_config_extremes();
    test_output_hold_off();

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
